// ----- rtl/core/srb_pkg.sv -----
`default_nettype none
package srb_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] REQ_ENQ = 2'd0;
	localparam logic [1:0] REQ_FETCH = 2'd1;
	localparam logic [1:0] REQ_CLEAN = 2'd2;
	localparam logic [1:0] REQ_RSVD = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NEWER = 2'd3;

	localparam logic CFG_QSIZE = 1'b0;
	localparam logic CFG_MAXAGE = 1'b1;

	// one stored entry
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] stamp;
		logic [15:0] pub;
		logic [31:0] data;
	} entry_t;

	// memory access request from the controller
	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		entry_t wdata;
		logic re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/srb_mem.sv -----
`default_nettype none
module srb_mem
	import srb_pkg::*;
(
	input  wire logic clk,
	input  mem_req_t req,
	output entry_t   rdata
);
	entry_t mem_q [DEPTH];

	// single write, single registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/srb_ctrl.sv -----
`default_nettype none
module srb_ctrl
	import srb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] now_time,
	input  wire logic [15:0] pub_id,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] last_seq,
	output mem_req_t         mreq,
	input  entry_t           rdata,
	output logic             done,
	output logic [1:0]       status,
	output entry_t           result
);
	typedef enum logic [2:0] {IDLE, FETCH1, FETCH2, CLEAN} state_t;

	state_t state_q;
	logic [4:0] qsize_q;
	logic [31:0] max_age_q;
	logic [IDX_W-1:0] head_q, tail_q, ptr_q;
	logic empty_q;
	logic [31:0] next_seq_q;
	logic [31:0] want_q, now_q;
	logic [CNT_W-1:0] left_q, cnt_q;
	logic rd_vld_q;

	logic [IDX_W-1:0] ring_n, tail_nxt, ptr_nxt, rd_ptr_q;
	logic [CNT_W-1:0] occ;
	logic [4:0] qs_clamp;

	// all removed when scan ran out without a young entry
	function automatic logic [CNT_W-1:0] occ_start(input logic [CNT_W-1:0] c,
	                                                input logic [CNT_W-1:0] l);
		return c + l;
	endfunction

	// ring length clamped to 2..DEPTH
	always_comb begin
		if (qsize_q < 5'd2) qs_clamp = 5'd2;
		else if (qsize_q > 5'(DEPTH)) qs_clamp = 5'(DEPTH);
		else qs_clamp = qsize_q;
		ring_n = IDX_W'(qs_clamp - 5'd1);
	end

	assign tail_nxt = (tail_q == ring_n) ? '0 : tail_q + 1'b1;
	assign ptr_nxt = (ptr_q == ring_n) ? '0 : ptr_q + 1'b1;

	always_comb begin
		if (empty_q) occ = '0;
		else if (head_q <= tail_q) occ = CNT_W'(tail_q - head_q) + 1'b1;
		else occ = CNT_W'(tail_q) + CNT_W'(qs_clamp) - CNT_W'(head_q) + 1'b1;
	end

	// memory port: read at scan pointer, write on enqueue
	always_comb begin
		mreq = '0;
		mreq.raddr = ptr_q;
		mreq.re = (state_q != IDLE) && (left_q != '0);
		if (state_q == IDLE && start && req_type == REQ_ENQ
		    && (empty_q || tail_nxt != head_q)) begin
			mreq.we = 1'b1;
			mreq.waddr = empty_q ? '0 : tail_nxt;
			mreq.wdata = '{seq: next_seq_q, stamp: now_time, pub: pub_id,
			               data: payload};
		end
	end

	assign busy = (state_q != IDLE);

	// sequencer: one slot read per cycle, data checked the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			qsize_q <= 5'd16;
			max_age_q <= 32'd1000000;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			next_seq_q <= 32'd1;
			done <= 1'b0;
			status <= ST_OK;
			result <= '0;
			ptr_q <= '0;
			rd_ptr_q <= '0;
			left_q <= '0;
			cnt_q <= '0;
			rd_vld_q <= 1'b0;
			want_q <= '0;
			now_q <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QSIZE: begin
						qsize_q <= cfg_data[4:0];
						head_q <= '0;
						tail_q <= '0;
						empty_q <= 1'b1;
					end
					CFG_MAXAGE: max_age_q <= cfg_data;
					default: ;
				endcase
			end
			rd_vld_q <= mreq.re;
			rd_ptr_q <= ptr_q;
			if (mreq.re) begin
				ptr_q <= ptr_nxt;
				left_q <= left_q - 1'b1;
			end
			unique case (state_q)
				IDLE: if (start) begin
					ptr_q <= head_q;
					left_q <= occ;
					cnt_q <= '0;
					want_q <= last_seq + 32'd1;
					now_q <= now_time;
					case (req_type)
						REQ_ENQ: begin
							done <= 1'b1;
							if (mreq.we) begin
								empty_q <= 1'b0;
								tail_q <= mreq.waddr;
								next_seq_q <= next_seq_q + 32'd1;
								status <= ST_OK;
								result <= mreq.wdata;
							end else begin
								status <= ST_FULL;
								result <= '0;
							end
						end
						REQ_FETCH: begin
							result <= '0;
							state_q <= FETCH1;
						end
						REQ_CLEAN: begin
							result <= '0;
							state_q <= CLEAN;
						end
						default: begin
							done <= 1'b1;
							status <= ST_NONE;
							result <= '0;
						end
					endcase
				end
				FETCH1, FETCH2: begin
					if (rd_vld_q && ((state_q == FETCH1 && rdata.seq == want_q)
					    || (state_q == FETCH2 && rdata.seq > want_q))) begin
						done <= 1'b1;
						status <= (state_q == FETCH1) ? ST_OK : ST_NEWER;
						result <= rdata;
						state_q <= IDLE;
					end else if (!rd_vld_q && left_q == '0 && !mreq.re) begin
						if (state_q == FETCH1 && occ != '0) begin
							state_q <= FETCH2;
							ptr_q <= head_q;
							left_q <= occ;
						end else begin
							done <= 1'b1;
							status <= ST_NONE;
							state_q <= IDLE;
						end
					end
				end
				CLEAN: begin
					if (rd_vld_q && (now_q - rdata.stamp) >= max_age_q) begin
						cnt_q <= cnt_q + 1'b1;
						head_q <= (rd_ptr_q == ring_n) ? '0 : rd_ptr_q + 1'b1;
					end else if (rd_vld_q || left_q == '0) begin
						// first young entry or end of queue
						done <= 1'b1;
						status <= (cnt_q != '0) ? ST_OK : ST_NONE;
						if (cnt_q != '0 && cnt_q == occ_start(cnt_q, left_q)
						    && !rd_vld_q) begin
							head_q <= '0;
							tail_q <= '0;
							empty_q <= 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// a scan never reads more slots than the ring holds
	property p_left;
		@(posedge clk) disable iff (!arst_n) left_q <= CNT_W'(DEPTH);
	endproperty
	a_left: assert property (p_left) else $error("scan count overflow");

	property p_done_idle;
		@(posedge clk) disable iff (!arst_n) done |-> state_q == IDLE;
	endproperty
	a_done_idle: assert property (p_done_idle) else $error("result while busy");

	property p_empty_ptrs;
		@(posedge clk) disable iff (!arst_n) empty_q |-> head_q == tail_q;
	endproperty
	a_empty_ptrs: assert property (p_empty_ptrs) else $error("empty with pointers apart");
endmodule
`default_nettype wire

// ----- rtl/core/sequenced_ring_buffer_with_aging_top.sv -----
// channel   | ports                                            | timing
// request   | start, busy, req_type, now_time, pub_id, payload, last_seq | start & !busy
// result    | done, status, entry_seq/time/pub_id/payload      | one cycle strobe
// config    | cfg_we, cfg_index, cfg_data                      | any edge with cfg_we
// enqueue and unused codes answer in the cycle after acceptance; cleanup and fetch scan
// the queue from the head, fetch in two passes (exact sequence, then newer), bound by the
// single read port of the slot memory, one slot a cycle.
// reset empties the queue and sets the sequence counter to 1; no memory clear.
// results cannot be stalled; busy is high from acceptance of a fetch or cleanup to its result.
`default_nettype none
module sequenced_ring_buffer_with_aging_top
	import srb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] now_time,
	input  wire logic [15:0] pub_id,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] last_seq,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      entry_seq,
	output logic [31:0]      entry_time,
	output logic [15:0]      entry_pub_id,
	output logic [31:0]      entry_payload
);
	mem_req_t mreq;
	entry_t rdata, res;

	srb_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));

	srb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_type(req_type), .now_time(now_time), .pub_id(pub_id),
		.payload(payload), .last_seq(last_seq), .mreq(mreq), .rdata(rdata),
		.done(done), .status(status), .result(res)
	);

	assign entry_seq = res.seq;
	assign entry_time = res.stamp;
	assign entry_pub_id = res.pub;
	assign entry_payload = res.data;
endmodule
`default_nettype wire

// ----- dv/srb_checker.sv -----
`default_nettype none
module srb_checker
	import srb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] now_time,
	input  wire logic [15:0] pub_id,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] last_seq,
	input  wire logic        done,
	input  wire logic [1:0]  status,
	input  wire logic [31:0] entry_seq,
	input  wire logic [31:0] entry_time,
	input  wire logic [15:0] entry_pub_id,
	input  wire logic [31:0] entry_payload,
	output int               fail_count,
	output int               pending,
	output logic [31:0]      seq_counter
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] st;
		entry_t     ent;
	} answer_t;

	// shadow state of the buffer
	logic [4:0]  qsize_reg;
	logic [31:0] age_limit;
	entry_t      ring [DEPTH];
	int          head, tail;
	bit          empty;
	logic [31:0] seq_next;
	answer_t     answers_due [$];

	int n_enq, n_fetch, n_clean, n_full, n_newer, n_exact;

	function automatic int slots_used();
		if (qsize_reg < 2) return 2;
		if (qsize_reg > DEPTH) return DEPTH;
		return qsize_reg;
	endfunction

	function automatic int step_idx(int i, int n);
		return (i + 1 >= n) ? 0 : i + 1;
	endfunction

	function automatic int fill_now();
		if (empty) return 0;
		if (head <= tail) return tail - head + 1;
		return tail + slots_used() - head + 1;
	endfunction

	assign seq_counter = seq_next;

	// predict the answer to one request and update the shadow
	function automatic answer_t predict_answer(logic [1:0] kind, logic [31:0] t,
			logic [15:0] pid, logic [31:0] word, logic [31:0] seen);
		answer_t a;
		int n, cnt, idx, i;
		logic [31:0] want;
		a = '0;
		a.st = ST_NONE;
		n = slots_used();
		cnt = fill_now();
		case (kind)
			REQ_ENQ: begin
				n_enq++;
				if (empty) begin
					head = 0; tail = 0; empty = 0;
				end else if (step_idx(tail, n) != head) begin
					tail = step_idx(tail, n);
				end else begin
					a.st = ST_FULL;
					n_full++;
					return a;
				end
				ring[tail] = '{seq: seq_next, stamp: t, pub: pid, data: word};
				seq_next = seq_next + 1;
				a.st = ST_OK;
				a.ent = ring[tail];
			end
			REQ_FETCH: begin
				n_fetch++;
				want = seen + 1;
				idx = head;
				for (i = 0; i < cnt; i++) begin
					if (ring[idx].seq == want) begin
						a.st = ST_OK; a.ent = ring[idx]; n_exact++;
						return a;
					end
					idx = step_idx(idx, n);
				end
				idx = head;
				for (i = 0; i < cnt; i++) begin
					if (ring[idx].seq > want) begin
						a.st = ST_NEWER; a.ent = ring[idx]; n_newer++;
						return a;
					end
					idx = step_idx(idx, n);
				end
			end
			REQ_CLEAN: begin
				n_clean++;
				idx = head;
				for (i = 0; i < cnt; i++) begin
					if (t - ring[idx].stamp < age_limit) break;
					idx = step_idx(idx, n);
				end
				if (i != 0) begin
					if (i == cnt) begin
						head = 0; tail = 0; empty = 1;
					end else begin
						head = idx;
					end
					a.st = ST_OK;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, exp);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			qsize_reg <= 5'd16;
			age_limit <= 32'd1000000;
			head = 0; tail = 0; empty = 1;
			seq_next = 1;
			answers_due.delete();
			pending = 0;
			fail_count <= 0;
		end else begin
			// compare a result strobe
			if (done) begin
				if (answers_due.size() == 0) begin
					report_mismatch("unexpected result", {30'd0, status}, 0);
				end else begin
					a = answers_due.pop_front();
					if (status != a.st) report_mismatch("status", status, a.st);
					if (entry_seq != a.ent.seq) report_mismatch("seq", entry_seq, a.ent.seq);
					if (entry_time != a.ent.stamp)
						report_mismatch("time", entry_time, a.ent.stamp);
					if (entry_pub_id != a.ent.pub)
						report_mismatch("pub_id", entry_pub_id, a.ent.pub);
					if (entry_payload != a.ent.data)
						report_mismatch("payload", entry_payload, a.ent.data);
				end
			end
			// register writes
			if (cfg_we) begin
				if (cfg_index == CFG_QSIZE) begin
					qsize_reg <= cfg_data[4:0];
					head = 0; tail = 0; empty = 1;
				end else begin
					age_limit <= cfg_data;
				end
			end
			// accepted request
			if (start && !busy)
				answers_due.push_back(predict_answer(req_type, now_time, pub_id,
					payload, last_seq));
			pending = answers_due.size();
		end
	end

	function automatic void print_coverage();
		$display("covered %0d enqueues (%0d full), %0d fetches (%0d exact, %0d newer)",
			n_enq, n_full, n_fetch, n_exact, n_newer);
		$display("and %0d cleanups across several queue sizes and age limits", n_clean);
	endfunction
endmodule
`default_nettype wire

// ----- dv/sequenced_ring_buffer_with_aging_top_tb.sv -----
`default_nettype none
module sequenced_ring_buffer_with_aging_top_tb;
	import srb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic        cfg_we = 0;
	logic        cfg_index = CFG_QSIZE;
	logic [31:0] cfg_data = '0;
	logic [1:0]  req_type = REQ_ENQ;
	logic [31:0] now_time = '0;
	logic [15:0] pub_id = '0;
	logic [31:0] payload = '0;
	logic [31:0] last_seq = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] entry_seq, entry_time, entry_payload;
	logic [15:0] entry_pub_id;
	int          fail_count, pending;
	logic [31:0] seq_counter;
	longint      cycles = 0;
	logic [31:0] clock_now = 0;
	bit          idle_enable = 1;

	localparam longint CYCLE_LIMIT = 400000;

	always #5 clk = ~clk;

	sequenced_ring_buffer_with_aging_top u_top (.*);
	srb_checker u_chk (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL sequenced_ring_buffer_with_aging_top");
			$finish;
		end
	end

	// issue one request and wait for acceptance; start stays high for a follow-up
	task automatic send_request(logic [1:0] kind, logic [31:0] t, logic [15:0] pid,
			logic [31:0] word, logic [31:0] seen);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		req_type <= kind;
		now_time <= t;
		pub_id <= pid;
		payload <= word;
		last_seq <= seen;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drain();
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		wait_drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// mostly realistic traffic with advancing time
	task automatic traffic(int count);
		int r;
		logic [31:0] seen;
		for (int k = 0; k < count; k++) begin
			clock_now += $urandom_range(0, 300);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_request(REQ_ENQ, clock_now, 16'($urandom), $urandom, $urandom);
			end else if (r < 80) begin
				case ($urandom_range(0, 3))
					0: seen = $urandom;
					1: seen = seq_counter - 1 - $urandom_range(0, 20);
					default: seen = seq_counter - 1 - $urandom_range(0, 6);
				endcase
				send_request(REQ_FETCH, clock_now, 16'($urandom), $urandom, seen);
			end else if (r < 97) begin
				send_request(REQ_CLEAN, clock_now, 16'($urandom), $urandom, $urandom);
			end else begin
				send_request(REQ_RSVD, $urandom, 16'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fill to full at reset size, field extremes, fetch cases
		send_request(REQ_FETCH, 0, 0, 0, 0);
		send_request(REQ_CLEAN, 0, 0, 0, 0);
		send_request(REQ_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
		send_request(REQ_ENQ, 0, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(REQ_FETCH, 5, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_FETCH, 5, 0, 0, 1);
		send_request(REQ_FETCH, 5, 0, 0, 0);
		send_request(REQ_FETCH, 5, 0, 0, 2);
		send_request(REQ_RSVD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (int k = 0; k < 15; k++) send_request(REQ_ENQ, 10 + k, 16'(k), k, 0);
		send_request(REQ_CLEAN, 32'd1000010, 0, 0, 0);
		send_request(REQ_CLEAN, 32'hFFFF_FFFF, 0, 0, 0);

		// phases over queue sizes and age limits
		write_reg(CFG_MAXAGE, 32'd0);
		send_request(REQ_ENQ, 7, 1, 1, 0);
		send_request(REQ_CLEAN, 7, 0, 0, 0);
		write_reg(CFG_QSIZE, 32'd2);
		write_reg(CFG_MAXAGE, 32'd600);
		clock_now = 1000;
		traffic(250);
		write_reg(CFG_QSIZE, 32'd0);
		write_reg(CFG_MAXAGE, 32'hFFFF_FFFF);
		traffic(200);
		write_reg(CFG_QSIZE, 32'd31);
		write_reg(CFG_MAXAGE, 32'd2000);
		traffic(300);
		write_reg(CFG_QSIZE, 32'd5);
		write_reg(CFG_MAXAGE, 32'd900);
		clock_now = 32'hFFFF_F000;
		traffic(300);
		write_reg(CFG_QSIZE, 32'd16);
		write_reg(CFG_MAXAGE, 32'd1500);
		traffic(350);
		idle_enable = 0;
		write_reg(CFG_QSIZE, 32'($urandom_range(2, 16)));
		write_reg(CFG_MAXAGE, 32'd1200);
		traffic(300);

		wait_drain();
		u_chk.print_coverage();
		if (fail_count == 0) begin
			$display("PASS sequenced_ring_buffer_with_aging_top");
		end else begin
			$display("FAIL sequenced_ring_buffer_with_aging_top");
		end
		$finish;
	end
endmodule
`default_nettype wire
